// File: src/stc3_pkg.sv
// Shared types, constants and helpers for the 3-column stencil convolution.
// Used by stencil_3_column_conv2d and stc3_checker; depends on nothing.
`timescale 1ns / 1ps

package stc3_pkg;

    localparam int PIXEL_BITS          = 16;
    localparam int COEFF_BITS          = 16;
    localparam int KERNEL_COLUMNS      = 3;
    localparam int NUM_COEFF_ROWS      = 5;
    localparam int COEFF_WORD_BITS     = COEFF_BITS * KERNEL_COLUMNS;
    localparam int OUT_VALUE_BITS      = 36;
    localparam int OUT_ROW_BITS        = 16;
    localparam int OUT_COL_BITS        = 10;
    localparam int CFG_WIDTH_BITS      = 11;
    localparam int CFG_HEIGHT_BITS     = 16;
    localparam int CFG_ROWS_BITS       = 3;
    localparam int CFG_INDEX_BITS      = 4;
    localparam int MAX_WIDTH_DEF       = 1024;
    localparam int MAX_KERNEL_ROWS_DEF = 5;
    localparam int DIV3_BITS           = 14;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 4'd0,
        CFG_IMAGE_HEIGHT = 4'd1,
        CFG_KERNEL_ROWS  = 4'd2,
        CFG_COEFF_A      = 4'd3,
        CFG_COEFF_B      = 4'd4,
        CFG_COEFF_C      = 4'd5,
        CFG_COEFF_D      = 4'd6,
        CFG_COEFF_E      = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic                         cmd;
        logic signed [PIXEL_BITS-1:0] pixel;
    } pix_item_t;

    typedef struct packed {
        logic signed [OUT_VALUE_BITS-1:0] out_value;
        logic [OUT_ROW_BITS-1:0]          out_row;
        logic [OUT_COL_BITS-1:0]          out_col;
        logic                             frame_done;
    } res_item_t;

    // Divide a column index by three: multiply by 2^17/3, exact below 2^13
    function automatic logic [DIV3_BITS-1:0] div3(input logic [DIV3_BITS-1:0] x);
        logic [29:0] prod;
        prod = 30'(x) * 30'(43691);
        return DIV3_BITS'(prod[29:17]);
    endfunction

endpackage

// File: src/stc3_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; read returns the old word on a same-address write.
`timescale 1ns / 1ps

module stc3_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 342,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/stencil_3_column_conv2d.sv
// Streaming 3-column by up to MAX_KERNEL_ROWS 2-D correlation with zero padding.
// Depends on stc3_pkg and stc3_ram (line store banks).
//
//   channel  direction  handshake                 payload
//   pix      in         pix_valid / pix_ready     stc3_pkg::pix_item_t
//   res      out        res_valid / res_ready     stc3_pkg::res_item_t
//   cfg      in         cfg_wr_en                 cfg_index, cfg_data
//
// One transaction per cycle on pix while pix_ready is high. A result from a
// transaction passes the line store read, multiply, row sum and output stages.
// The line store is (MAX_KERNEL_ROWS+1) row slots, each split into three
// column banks, so the three columns of a window come from one read each.
// Reset clears counters and pipeline valids; the line store is not cleared.
// A stalled res channel backs up through the four registered stages.
`timescale 1ns / 1ps

module stencil_3_column_conv2d #(
    parameter int MAX_WIDTH       = stc3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_KERNEL_ROWS = stc3_pkg::MAX_KERNEL_ROWS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pix_valid,
    output logic                                  pix_ready,
    input  stc3_pkg::pix_item_t                   pix_data,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output stc3_pkg::res_item_t                   res_data,
    input  logic                                  cfg_wr_en,
    input  logic [stc3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [stc3_pkg::COEFF_WORD_BITS-1:0]  cfg_data
);

    import stc3_pkg::*;

    localparam int S       = MAX_KERNEL_ROWS + 1;
    localparam int SB      = $clog2(S);
    localparam int WB      = $clog2(MAX_WIDTH + 1);
    localparam int CB      = $clog2(MAX_WIDTH);
    localparam int CWB     = (WB > CFG_WIDTH_BITS) ? WB : CFG_WIDTH_BITS;
    localparam int DEPTH   = (MAX_WIDTH + 2) / 3;
    localparam int AB      = $clog2(DEPTH);
    localparam int PB      = CFG_HEIGHT_BITS + WB + 1;
    localparam int CR      = (MAX_KERNEL_ROWS > NUM_COEFF_ROWS) ?
                             MAX_KERNEL_ROWS : NUM_COEFF_ROWS;
    localparam int PRODW   = PIXEL_BITS + COEFF_BITS;
    localparam int RSW     = PRODW + 2;
    localparam int ACCW    = OUT_VALUE_BITS + 1 + $clog2(MAX_KERNEL_ROWS + 1);
    localparam int YB      = CFG_HEIGHT_BITS + 2;
    localparam int TB      = SB + 3;

    // Configuration registers
    logic [CFG_WIDTH_BITS-1:0]  width_cfg_reg;
    logic [CFG_HEIGHT_BITS-1:0] height_cfg_reg;
    logic [CFG_ROWS_BITS-1:0]   rows_cfg_reg;
    logic [COEFF_WORD_BITS-1:0] coeff_reg [CR];

    // Position counters
    logic [CB-1:0]              in_col_reg, in_col_next;
    logic [CFG_HEIGHT_BITS-1:0] in_row_reg, in_row_next;
    logic [SB-1:0]              in_slot_reg, in_slot_next;
    logic [CB-1:0]              em_col_reg, em_col_next;
    logic [CFG_HEIGHT_BITS-1:0] em_row_reg, em_row_next;
    logic [SB-1:0]              em_slot_reg, em_slot_next;
    logic                       complete_reg, complete_next;

    // Effective configuration
    logic [WB-1:0]              w_eff;
    logic [CFG_HEIGHT_BITS-1:0] h_eff;
    logic [CFG_ROWS_BITS-1:0]   r_eff;
    logic [CFG_ROWS_BITS-1:0]   mid;

    // Accept-cycle decode
    logic          accept, is_flush, do_write, do_emit, frame_end;
    logic [PB-1:0] in_pos, latency, em_pos, last_pos;
    logic [CB-1:0] wr_col;
    logic [DIV3_BITS-1:0] wr_q, em_q, wr_rem, em_rem;
    logic [1:0]    wr_bank, em_m;
    logic [AB-1:0] wr_addr;
    logic [1:0]    col_bank  [KERNEL_COLUMNS];
    logic [AB-1:0] col_addr  [KERNEL_COLUMNS];
    logic          col_ok    [KERNEL_COLUMNS];
    logic [AB-1:0] bank_addr [KERNEL_COLUMNS];
    logic [SB-1:0] row_slot  [MAX_KERNEL_ROWS];
    logic          row_ok    [MAX_KERNEL_ROWS];
    logic          wr_en_arr [S][KERNEL_COLUMNS];
    logic          fwd_arr   [S][KERNEL_COLUMNS];

    // Line store read data
    logic [PIXEL_BITS-1:0] ram_q [S][KERNEL_COLUMNS];

    // Read stage
    logic                         rd_v_reg;
    logic [SB-1:0]                rd_slot_reg [MAX_KERNEL_ROWS];
    logic                         rd_rok_reg  [MAX_KERNEL_ROWS];
    logic [1:0]                   rd_bank_reg [KERNEL_COLUMNS];
    logic                         rd_cok_reg  [KERNEL_COLUMNS];
    logic                         rd_fwd_reg  [S][KERNEL_COLUMNS];
    logic signed [PIXEL_BITS-1:0] rd_pix_reg;
    logic [CFG_HEIGHT_BITS-1:0]   rd_row_reg;
    logic [CB-1:0]                rd_col_reg;
    logic                         rd_done_reg;

    // Product stage
    logic                       prod_v_reg;
    logic signed [PRODW-1:0]    prod_reg [MAX_KERNEL_ROWS][KERNEL_COLUMNS];
    logic signed [PRODW-1:0]    prod_next [MAX_KERNEL_ROWS][KERNEL_COLUMNS];
    logic [CFG_HEIGHT_BITS-1:0] prod_row_reg;
    logic [CB-1:0]              prod_col_reg;
    logic                       prod_done_reg;

    // Row sum stage
    logic                       sum_v_reg;
    logic signed [RSW-1:0]      rowsum_reg [MAX_KERNEL_ROWS];
    logic signed [RSW-1:0]      rowsum_next [MAX_KERNEL_ROWS];
    logic [CFG_HEIGHT_BITS-1:0] sum_row_reg;
    logic [CB-1:0]              sum_col_reg;
    logic                       sum_done_reg;
    logic signed [ACCW-1:0]     total;

    // Output register
    logic      res_valid_reg;
    res_item_t res_reg;

    // Stage flow control
    logic out_free, sum_free, prod_free, rd_free;

    assign out_free  = !res_valid_reg || res_ready;
    assign sum_free  = !sum_v_reg || out_free;
    assign prod_free = !prod_v_reg || sum_free;
    assign rd_free   = !rd_v_reg || prod_free;
    assign pix_ready = rd_free;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFG_WIDTH_BITS'(1024);
            height_cfg_reg <= CFG_HEIGHT_BITS'(1);
            rows_cfg_reg   <= CFG_ROWS_BITS'(3);
            for (int i = 0; i < CR; i++)
            begin
                coeff_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data[CFG_WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data[CFG_HEIGHT_BITS-1:0];
                CFG_KERNEL_ROWS:  rows_cfg_reg   <= cfg_data[CFG_ROWS_BITS-1:0];
                CFG_COEFF_A:      coeff_reg[0]   <= cfg_data;
                CFG_COEFF_B:      coeff_reg[1]   <= cfg_data;
                CFG_COEFF_C:      coeff_reg[2]   <= cfg_data;
                CFG_COEFF_D:      coeff_reg[3]   <= cfg_data;
                CFG_COEFF_E:      coeff_reg[4]   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Clamp configuration to its working range
    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            w_eff = WB'(1);
        end
        else if (CWB'(width_cfg_reg) > CWB'(MAX_WIDTH))
        begin
            w_eff = WB'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WB'(width_cfg_reg);
        end
        h_eff = (height_cfg_reg == '0) ? CFG_HEIGHT_BITS'(1) : height_cfg_reg;
        if (rows_cfg_reg == '0)
        begin
            r_eff = CFG_ROWS_BITS'(1);
        end
        else if (rows_cfg_reg > CFG_ROWS_BITS'(MAX_KERNEL_ROWS))
        begin
            r_eff = CFG_ROWS_BITS'(MAX_KERNEL_ROWS);
        end
        else
        begin
            r_eff = rows_cfg_reg;
        end
        mid = r_eff >> 1;
    end

    // Decide write and emit for the incoming transaction
    assign accept   = pix_valid && pix_ready;
    assign is_flush = (pix_data.cmd == CMD_FLUSH);
    assign in_pos   = PB'(in_row_reg) * PB'(w_eff) + PB'(in_col_reg);
    assign latency  = PB'(r_eff - CFG_ROWS_BITS'(1) - mid) * PB'(w_eff) + PB'(1);
    assign em_pos   = PB'(em_row_reg) * PB'(w_eff) + PB'(em_col_reg);
    assign last_pos = PB'(w_eff) * PB'(h_eff) - PB'(1);
    assign frame_end = (em_pos >= last_pos);
    assign do_write = accept && !is_flush && !complete_reg;
    assign do_emit  = accept && (is_flush ? complete_reg
                                          : (!complete_reg && (in_pos >= latency)));

    // Write location: slot of the input row, bank and address of the column
    always_comb
    begin
        if (WB'(in_col_reg) < w_eff)
        begin
            wr_col = in_col_reg;
        end
        else
        begin
            wr_col = CB'(w_eff - WB'(1));
        end
        wr_q    = div3(DIV3_BITS'(wr_col));
        wr_rem  = DIV3_BITS'(wr_col) - wr_q * DIV3_BITS'(3);
        wr_bank = wr_rem[1:0];
        wr_addr = wr_q[AB-1:0];
    end

    // Read locations: the three window columns fall in three distinct banks
    always_comb
    begin
        em_q   = div3(DIV3_BITS'(em_col_reg));
        em_rem = DIV3_BITS'(em_col_reg) - em_q * DIV3_BITS'(3);
        em_m   = em_rem[1:0];

        col_bank[1] = em_m;
        col_addr[1] = em_q[AB-1:0];
        col_ok[1]   = (WB'(em_col_reg) < w_eff);

        col_bank[0] = (em_m == 2'd0) ? 2'd2 : em_m - 2'd1;
        col_addr[0] = (em_m == 2'd0) ? AB'(em_q - DIV3_BITS'(1)) : em_q[AB-1:0];
        col_ok[0]   = (em_col_reg != '0) && (WB'(em_col_reg) <= w_eff);

        col_bank[2] = (em_m == 2'd2) ? 2'd0 : em_m + 2'd1;
        col_addr[2] = (em_m == 2'd2) ? AB'(em_q + DIV3_BITS'(1)) : em_q[AB-1:0];
        col_ok[2]   = ((WB + 1)'(em_col_reg) + (WB + 1)'(1) < (WB + 1)'(w_eff));

        for (int b = 0; b < KERNEL_COLUMNS; b++)
        begin
            if (col_bank[0] == 2'(b))
            begin
                bank_addr[b] = col_addr[0];
            end
            else if (col_bank[1] == 2'(b))
            begin
                bank_addr[b] = col_addr[1];
            end
            else
            begin
                bank_addr[b] = col_addr[2];
            end
        end
    end

    // Kernel rows: image row, slot and in-frame check
    always_comb
    begin
        logic signed [YB-1:0] y;
        logic [TB-1:0]        t;
        for (int r = 0; r < MAX_KERNEL_ROWS; r++)
        begin
            y = $signed({2'b00, em_row_reg}) + YB'(r) - $signed(YB'(mid));
            row_ok[r] = (CFG_ROWS_BITS'(r) < r_eff) && (y >= 0) &&
                        (y < $signed({2'b00, h_eff}));
            t = TB'(em_slot_reg) + TB'(S) + TB'(r) - TB'(mid);
            if (t >= TB'(2 * S))
            begin
                t = t - TB'(2 * S);
            end
            else if (t >= TB'(S))
            begin
                t = t - TB'(S);
            end
            row_slot[r] = t[SB-1:0];
        end
    end

    // Bank write enables and same-address forwarding flags
    always_comb
    begin
        for (int s = 0; s < S; s++)
        begin
            for (int b = 0; b < KERNEL_COLUMNS; b++)
            begin
                wr_en_arr[s][b] = do_write && (in_slot_reg == SB'(s)) &&
                                  (wr_bank == 2'(b));
                fwd_arr[s][b]   = wr_en_arr[s][b] && (wr_addr == bank_addr[b]);
            end
        end
    end

    // Line store banks
    for (genvar gs = 0; gs < S; gs++)
    begin : g_slot
        for (genvar gb = 0; gb < KERNEL_COLUMNS; gb++)
        begin : g_bank
            stc3_ram #(
                .WIDTH (PIXEL_BITS),
                .DEPTH (DEPTH)
            ) u_ram (
                .clk     (clk),
                .wr_en   (wr_en_arr[gs][gb]),
                .wr_addr (wr_addr),
                .wr_data (pix_data.pixel),
                .rd_en   (do_emit),
                .rd_addr (bank_addr[gb]),
                .rd_data (ram_q[gs][gb])
            );
        end
    end

    // Advance input and emit positions
    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        em_col_next   = em_col_reg;
        em_row_next   = em_row_reg;
        em_slot_next  = em_slot_reg;
        complete_next = complete_reg;
        if (do_write)
        begin
            if ((WB + 1)'(in_col_reg) + (WB + 1)'(1) >= (WB + 1)'(w_eff))
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + CFG_HEIGHT_BITS'(1);
                in_slot_next = (in_slot_reg == SB'(S - 1)) ? '0 : in_slot_reg + SB'(1);
                if ((CFG_HEIGHT_BITS + 1)'(in_row_reg) + (CFG_HEIGHT_BITS + 1)'(1) >=
                    (CFG_HEIGHT_BITS + 1)'(h_eff))
                begin
                    complete_next = 1'b1;
                end
            end
            else
            begin
                in_col_next = in_col_reg + CB'(1);
            end
        end
        if (do_emit)
        begin
            if (frame_end)
            begin
                in_col_next   = '0;
                in_row_next   = '0;
                in_slot_next  = '0;
                em_col_next   = '0;
                em_row_next   = '0;
                em_slot_next  = '0;
                complete_next = 1'b0;
            end
            else if ((WB + 1)'(em_col_reg) + (WB + 1)'(1) >= (WB + 1)'(w_eff))
            begin
                em_col_next  = '0;
                em_row_next  = em_row_reg + CFG_HEIGHT_BITS'(1);
                em_slot_next = (em_slot_reg == SB'(S - 1)) ? '0 : em_slot_reg + SB'(1);
            end
            else
            begin
                em_col_next = em_col_reg + CB'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            em_col_reg   <= '0;
            em_row_reg   <= '0;
            em_slot_reg  <= '0;
            complete_reg <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            em_col_reg   <= em_col_next;
            em_row_reg   <= em_row_next;
            em_slot_reg  <= em_slot_next;
            complete_reg <= complete_next;
        end
    end

    // Read stage: hold window selects while the banks fetch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
        end
        else if (rd_free)
        begin
            rd_v_reg <= do_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_free && do_emit)
        begin
            for (int r = 0; r < MAX_KERNEL_ROWS; r++)
            begin
                rd_slot_reg[r] <= row_slot[r];
                rd_rok_reg[r]  <= row_ok[r];
            end
            for (int c = 0; c < KERNEL_COLUMNS; c++)
            begin
                rd_bank_reg[c] <= col_bank[c];
                rd_cok_reg[c]  <= col_ok[c];
            end
            rd_fwd_reg  <= fwd_arr;
            rd_pix_reg  <= pix_data.pixel;
            rd_row_reg  <= em_row_reg;
            rd_col_reg  <= em_col_reg;
            rd_done_reg <= frame_end;
        end
    end

    // Select window samples and multiply by the coefficients
    always_comb
    begin
        logic signed [PIXEL_BITS-1:0] smp;
        logic signed [COEFF_BITS-1:0] cf;
        for (int r = 0; r < MAX_KERNEL_ROWS; r++)
        begin
            for (int c = 0; c < KERNEL_COLUMNS; c++)
            begin
                if (rd_fwd_reg[rd_slot_reg[r]][rd_bank_reg[c]])
                begin
                    smp = rd_pix_reg;
                end
                else
                begin
                    smp = $signed(ram_q[rd_slot_reg[r]][rd_bank_reg[c]]);
                end
                if (!(rd_rok_reg[r] && rd_cok_reg[c]))
                begin
                    smp = '0;
                end
                cf = $signed(coeff_reg[r][COEFF_BITS*c +: COEFF_BITS]);
                prod_next[r][c] = PRODW'(smp) * PRODW'(cf);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else if (prod_free)
        begin
            prod_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_free && rd_v_reg)
        begin
            prod_reg      <= prod_next;
            prod_row_reg  <= rd_row_reg;
            prod_col_reg  <= rd_col_reg;
            prod_done_reg <= rd_done_reg;
        end
    end

    // Sum the three products of each kernel row
    always_comb
    begin
        for (int r = 0; r < MAX_KERNEL_ROWS; r++)
        begin
            rowsum_next[r] = RSW'(prod_reg[r][0]) + RSW'(prod_reg[r][1]) +
                             RSW'(prod_reg[r][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_v_reg <= 1'b0;
        end
        else if (sum_free)
        begin
            sum_v_reg <= prod_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_free && prod_v_reg)
        begin
            rowsum_reg   <= rowsum_next;
            sum_row_reg  <= prod_row_reg;
            sum_col_reg  <= prod_col_reg;
            sum_done_reg <= prod_done_reg;
        end
    end

    // Add the row sums into the result
    always_comb
    begin
        total = '0;
        for (int r = 0; r < MAX_KERNEL_ROWS; r++)
        begin
            total = total + ACCW'(rowsum_reg[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= sum_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && sum_v_reg)
        begin
            res_reg.out_value  <= total[OUT_VALUE_BITS-1:0];
            res_reg.out_row    <= sum_row_reg;
            res_reg.out_col    <= OUT_COL_BITS'(sum_col_reg);
            res_reg.frame_done <= sum_done_reg;
        end
    end

endmodule

// File: src/stc3_checker.sv
// Port-level checks for stencil_3_column_conv2d, bound to every instance.
// Depends on stc3_pkg for the channel payload types.
`timescale 1ns / 1ps

module stc3_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 pix_valid,
    input logic                                 pix_ready,
    input logic                                 res_valid,
    input logic                                 res_ready,
    input stc3_pkg::res_item_t                  res_data
);

    import stc3_pkg::*;

    // Hold a stalled result transaction
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed or dropped while stalled");

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid right after reset");

    // A result that appears in an empty output must follow an accepted input transaction
    a_res_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pix_valid && pix_ready, 4))
        else $error("result appeared without a matching input transaction");

endmodule

bind stencil_3_column_conv2d stc3_checker u_stc3_checker (.*);

// File: sim/stencil_3_column_conv2d_tb.sv
// Self-checking testbench for stencil_3_column_conv2d: directed frames, then random frames.
// Depends on stc3_pkg and the stencil_3_column_conv2d RTL; needs no files or arguments.
`timescale 1ns / 1ps

module stencil_3_column_conv2d_tb;
    import stc3_pkg::*;

    localparam int STORE_SLOTS  = 6;
    localparam int LINE_PIXELS  = 1024;
    localparam int ITEM_TARGET  = 1900;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        bit                          is_cfg;
        cfg_index_t                  idx;
        logic [COEFF_WORD_BITS-1:0]  data;
        pix_item_t                   item;
        bit                          typed;
        res_item_t                   want;
    } step_t;

    logic                        clk;
    logic                        rst_n;
    logic                        pix_valid;
    logic                        pix_ready;
    pix_item_t                   pix_data;
    logic                        res_valid;
    logic                        res_ready;
    res_item_t                   res_data;
    logic                        cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [COEFF_WORD_BITS-1:0]  cfg_data;

    // Shadow of the block: configuration, line store and raster counters
    logic [CFG_WIDTH_BITS-1:0]   shadow_width;
    logic [CFG_HEIGHT_BITS-1:0]  shadow_height;
    logic [CFG_ROWS_BITS-1:0]    shadow_rows;
    logic [COEFF_WORD_BITS-1:0]  shadow_coeff [NUM_COEFF_ROWS];
    int                          line_mem [STORE_SLOTS][LINE_PIXELS];
    int unsigned                 next_in_col, next_in_row, next_out_col, next_out_row;
    bit                          draining;

    res_item_t                   pending_results [$];
    step_t                       directed_steps [$];
    int                          idle_pct;
    int                          stall_pct;
    int                          mismatch_count;
    int                          result_count;
    int                          item_count;
    int                          frame_count;
    int                          quiet_cycles;

    stencil_3_column_conv2d uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int unsigned active_width();
        if (shadow_width == 0) return 1;
        if (shadow_width > LINE_PIXELS) return LINE_PIXELS;
        return shadow_width;
    endfunction

    function automatic int unsigned active_height();
        return (shadow_height == 0) ? 1 : shadow_height;
    endfunction

    function automatic int unsigned active_rows();
        if (shadow_rows == 0) return 1;
        if (shadow_rows > MAX_KERNEL_ROWS_DEF) return MAX_KERNEL_ROWS_DEF;
        return shadow_rows;
    endfunction

    // Correlate the window centered on one output pixel, zero outside the image
    function automatic longint window_sum(int unsigned ey, int unsigned ex);
        int     w;
        int     h;
        int     rows;
        int     mid;
        int     y;
        int     x;
        longint acc;
        w = active_width();
        h = active_height();
        rows = active_rows();
        mid = rows / 2;
        acc = 0;
        for (int r = 0; r < rows; r++)
        begin
            y = int'(ey) + r - mid;
            if (y < 0 || y >= h) continue;
            for (int c = 0; c < KERNEL_COLUMNS; c++)
            begin
                x = int'(ex) + c - 1;
                if (x < 0 || x >= w) continue;
                acc += longint'($signed(shadow_coeff[r][COEFF_BITS*c +: COEFF_BITS]))
                       * longint'(line_mem[y % STORE_SLOTS][x]);
            end
        end
        return acc;
    endfunction

    // Emit the next output pixel and advance or wrap the output position
    task automatic emit_next(output res_item_t r);
        longint unsigned pos;
        longint unsigned last;
        longint          acc;
        bit              done;
        pos = longint'(next_out_row) * active_width() + next_out_col;
        last = longint'(active_width()) * active_height() - 1;
        done = (pos >= last);
        acc = window_sum(next_out_row, next_out_col);
        r.out_value = acc[OUT_VALUE_BITS-1:0];
        r.out_row = next_out_row[OUT_ROW_BITS-1:0];
        r.out_col = next_out_col[OUT_COL_BITS-1:0];
        r.frame_done = done;
        if (done)
        begin
            next_in_row = 0;
            next_in_col = 0;
            next_out_row = 0;
            next_out_col = 0;
            draining = 1'b0;
        end
        else if (++next_out_col >= active_width())
        begin
            next_out_col = 0;
            next_out_row++;
        end
    endtask

    // Advance the shadow by one accepted transaction
    task automatic predict_item(input pix_item_t it, output bit got, output res_item_t r);
        int unsigned     w;
        int unsigned     rows;
        int unsigned     col;
        longint unsigned p;
        longint unsigned lat;
        w = active_width();
        rows = active_rows();
        got = 1'b0;
        r = '0;
        if (it.cmd == CMD_FLUSH)
        begin
            if (draining)
            begin
                emit_next(r);
                got = 1'b1;
            end
        end
        else if (!draining)
        begin
            p = longint'(next_in_row) * w + next_in_col;
            lat = longint'(rows - 1 - rows / 2) * w + 1;
            col = (next_in_col < w) ? next_in_col : w - 1;
            line_mem[next_in_row % STORE_SLOTS][col] = int'(it.pixel);
            if (++next_in_col >= w)
            begin
                next_in_col = 0;
                if (++next_in_row >= active_height()) draining = 1'b1;
            end
            if (p >= lat)
            begin
                emit_next(r);
                got = 1'b1;
            end
        end
    endtask

    // Write one register and mirror it in the shadow
    task automatic write_reg(cfg_index_t idx, logic [COEFF_WORD_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_IMAGE_WIDTH:  shadow_width = value[CFG_WIDTH_BITS-1:0];
            CFG_IMAGE_HEIGHT: shadow_height = value[CFG_HEIGHT_BITS-1:0];
            CFG_KERNEL_ROWS:  shadow_rows = value[CFG_ROWS_BITS-1:0];
            default:          shadow_coeff[idx - CFG_COEFF_A] = value;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and hold until every expected result has left the block
    task automatic wait_idle(bit settle);
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Present one transaction, with random gaps, and predict it on acceptance
    task automatic send_item(pix_item_t it, bit typed, res_item_t want);
        bit        got;
        res_item_t r;
        if ($urandom_range(99) < idle_pct)
        begin
            pix_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        pix_valid <= 1'b1;
        pix_data  <= it;
        do @(posedge clk); while (!pix_ready);
        predict_item(it, got, r);
        if (got) pending_results.push_back(typed ? want : r);
    endtask

    task automatic add_cfg(cfg_index_t idx, logic [COEFF_WORD_BITS-1:0] value);
        step_t s;
        s = '{idx: CFG_IMAGE_WIDTH, default: '0};
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.data = value;
        directed_steps.push_back(s);
    endtask

    task automatic add_item(logic cmd, logic signed [PIXEL_BITS-1:0] pix, bit typed,
                            logic signed [OUT_VALUE_BITS-1:0] value,
                            int unsigned row, int unsigned col, bit done);
        step_t s;
        s = '{idx: CFG_IMAGE_WIDTH, default: '0};
        s.item.cmd = cmd;
        s.item.pixel = pix;
        s.typed = typed;
        s.want = '{out_value: value, out_row: row[OUT_ROW_BITS-1:0],
                   out_col: col[OUT_COL_BITS-1:0], frame_done: done};
        directed_steps.push_back(s);
    endtask

    function automatic logic signed [PIXEL_BITS-1:0] pick_pixel();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [COEFF_WORD_BITS-1:0] pick_coeffs();
        case ($urandom_range(7))
            0:       return 48'h8000_8000_8000;
            1:       return 48'h7fff_7fff_7fff;
            default: return COEFF_WORD_BITS'({$urandom, $urandom});
        endcase
    endfunction

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: value=%0d row=%0d col=%0d done=%0b",
                             res_data.out_value, res_data.out_row, res_data.out_col,
                             res_data.frame_done);
            end
            else
            begin
                res_item_t e;
                e = pending_results.pop_front();
                if (res_data.out_value !== e.out_value || res_data.out_row !== e.out_row ||
                    res_data.out_col !== e.out_col || res_data.frame_done !== e.frame_done)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d r%0d c%0d d%0b, got %0d r%0d c%0d d%0b",
                                 e.out_value, e.out_row, e.out_col, e.frame_done,
                                 res_data.out_value, res_data.out_row, res_data.out_col,
                                 res_data.frame_done);
                end
            end
        end
    end

    // Randomly stall the result channel
    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= stall_pct);
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((pix_valid && pix_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[stencil_3_column_conv2d] ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned npix;
        int unsigned w;
        int unsigned h;
        bit          wide_done;
        pix_item_t   it;

        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix_data = '0;
        res_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        mismatch_count = 0;
        result_count = 0;
        item_count = 0;
        frame_count = 0;
        quiet_cycles = 0;
        wide_done = 1'b0;
        shadow_width = 11'd1024;
        shadow_height = 16'd1;
        shadow_rows = 3'd3;
        foreach (shadow_coeff[i]) shadow_coeff[i] = '0;
        foreach (line_mem[i, j]) line_mem[i][j] = 0;
        next_in_col = 0;
        next_in_row = 0;
        next_out_col = 0;
        next_out_row = 0;
        draining = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-row kernel, center tap at its most negative: outputs are -32768 * pixel
        add_cfg(CFG_IMAGE_HEIGHT, 48'd65535);
        add_cfg(CFG_IMAGE_WIDTH, 48'd3);
        add_cfg(CFG_IMAGE_HEIGHT, 48'd2);
        add_cfg(CFG_KERNEL_ROWS, 48'd1);
        add_cfg(CFG_COEFF_A, 48'h0000_8000_0000);
        add_item(CMD_FLUSH, 16'sd0, 1'b0, '0, 0, 0, 1'b0);
        add_item(CMD_PIXEL, 16'sh8000, 1'b0, '0, 0, 0, 1'b0);
        add_item(CMD_PIXEL, 16'sd32767, 1'b1, 36'sd1073741824, 0, 0, 1'b0);
        add_item(CMD_PIXEL, 16'sd0, 1'b1, -36'sd1073709056, 0, 1, 1'b0);
        add_item(CMD_PIXEL, 16'sd1, 1'b1, 36'sd0, 0, 2, 1'b0);
        add_item(CMD_PIXEL, -16'sd1, 1'b1, -36'sd32768, 1, 0, 1'b0);
        add_item(CMD_PIXEL, 16'sd12345, 1'b1, 36'sd32768, 1, 1, 1'b0);
        add_item(CMD_PIXEL, 16'sd7, 1'b0, '0, 0, 0, 1'b0);
        add_item(CMD_FLUSH, 16'sd0, 1'b1, -36'sd404520960, 1, 2, 1'b1);
        add_item(CMD_FLUSH, 16'sd0, 1'b0, '0, 0, 0, 1'b0);
        // Zero registers act as one: a one-pixel frame
        add_cfg(CFG_IMAGE_WIDTH, 48'd0);
        add_cfg(CFG_IMAGE_HEIGHT, 48'd0);
        add_cfg(CFG_KERNEL_ROWS, 48'd0);
        add_cfg(CFG_COEFF_A, 48'hffff_ffff_ffff);
        add_cfg(CFG_COEFF_B, 48'h7fff_8000_7fff);
        add_cfg(CFG_COEFF_C, 48'h8000_7fff_8000);
        add_cfg(CFG_COEFF_D, 48'h0000_0000_0000);
        add_cfg(CFG_COEFF_E, 48'h7fff_7fff_7fff);
        add_item(CMD_PIXEL, 16'sd32767, 1'b0, '0, 0, 0, 1'b0);
        add_item(CMD_FLUSH, 16'sd0, 1'b0, '0, 0, 0, 1'b0);

        // Walk the directed table
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].is_cfg)
            begin
                wait_idle(1'b1);
                write_reg(directed_steps[i].idx, directed_steps[i].data);
            end
            else
            begin
                send_item(directed_steps[i].item, directed_steps[i].typed,
                          directed_steps[i].want);
                item_count++;
            end
        end
        frame_count = 2;

        // Random frames, reconfigured between frames
        while (item_count < ITEM_TARGET)
        begin
            wait_idle(1'b1);
            case (frame_count % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            case ($urandom_range(19))
                0:       w = 0;
                1:       w = wide_done ? $urandom_range(1, 16) : 2047;
                2, 3, 4: w = $urandom_range(17, 40);
                default: w = $urandom_range(1, 16);
            endcase
            h = (w == 2047) ? 1 : $urandom_range(0, 6);
            if (w == 2047) wide_done = 1'b1;
            write_reg(CFG_IMAGE_WIDTH, 48'(w));
            write_reg(CFG_IMAGE_HEIGHT, 48'(h));
            write_reg(CFG_KERNEL_ROWS, 48'($urandom_range(0, 7)));
            for (int r = 0; r < NUM_COEFF_ROWS; r++)
                write_reg(cfg_index_t'(CFG_COEFF_A + r), pick_coeffs());

            npix = active_width() * active_height();
            for (int unsigned p = 0; p < npix; p++)
            begin
                // Early flushes are ignored while input is still arriving
                if ($urandom_range(99) < 4)
                begin
                    it = '{cmd: CMD_FLUSH, pixel: pick_pixel()};
                    send_item(it, 1'b0, '0);
                end
                if (frame_count == 5 && p == npix / 2) wait_idle(1'b0);
                it = '{cmd: CMD_PIXEL, pixel: pick_pixel()};
                send_item(it, 1'b0, '0);
                item_count++;
            end
            // Drain, with stray pixels that the block must ignore
            while (draining)
            begin
                if ($urandom_range(4) == 0)
                begin
                    it = '{cmd: CMD_PIXEL, pixel: pick_pixel()};
                    send_item(it, 1'b0, '0);
                end
                it = '{cmd: CMD_FLUSH, pixel: pick_pixel()};
                send_item(it, 1'b0, '0);
                item_count++;
            end
            frame_count++;
        end

        wait_idle(1'b1);
        $display("ran %0d frames (widths to 1024, kernels of 1 to 5 rows), %0d transactions,",
                 frame_count, item_count);
        $display("%0d results checked, %0d mismatches", result_count, mismatch_count);
        if (mismatch_count == 0)
            $display("[stencil_3_column_conv2d] OK");
        else
            $display("[stencil_3_column_conv2d] ERROR");
        $finish;
    end

endmodule
